@@ rtl/core/dht22_pulse_width_receiver_macros.svh @@
// ---------------------------------------------------------------------------
// dht22_pulse_width_receiver_macros: assertion helpers
// Concurrent assertion shorthands for the pulse-width receiver.
// ---------------------------------------------------------------------------
`ifndef DHT22_PULSE_WIDTH_RECEIVER_MACROS_SVH
`define DHT22_PULSE_WIDTH_RECEIVER_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is active.
`define DPWR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DPWR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dpwr_pkg.sv @@
// ---------------------------------------------------------------------------
// dpwr_pkg: shared types and constants
// Frame record, configuration bundle and queue status for the receiver.
// ---------------------------------------------------------------------------
package dpwr_pkg;

  // Capture ends once this many phases have closed.
  localparam int unsigned PHASE_LIMIT = 85;
  localparam int unsigned PHASE_W     = 7;
  localparam int unsigned FRAME_BITS  = 40;
  localparam int unsigned TOTAL_W     = 6;
  localparam int unsigned READING_W   = 13;

  localparam logic [PHASE_W-1:0] PHASE_LIMIT_C   = PHASE_W'(PHASE_LIMIT);
  localparam logic [PHASE_W-1:0] FIRST_BIT_PHASE = 7'd4;
  localparam logic [TOTAL_W-1:0] FRAME_BIT_COUNT = TOTAL_W'(FRAME_BITS);

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned    CFG_IDX_W         = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 2'd1;

  localparam logic [7:0] BIT_THRESHOLD_RST = 8'd50;
  localparam logic [7:0] TIMEOUT_COUNT_RST = 8'd255;

  // Value reported for humidity and temperature on a failed reading
  localparam logic signed [READING_W-1:0] READING_FAIL = -13'sd10;

  // Frame queue geometry (depth is a power of two)
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [7:0] bit_threshold;
    logic [7:0] timeout_count;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] bits;
    logic [TOTAL_W-1:0]    total;
  } frame_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

endpackage

@@ rtl/core/dht22_pulse_width_receiver.sv @@
// ---------------------------------------------------------------------------
// dht22_pulse_width_receiver: single-wire sensor pulse-width decoder
// Throughput: one input item per cycle; input ready drops only while the frame queue is full.
// Result path: a closed frame enters the frame queue, then moves to the output register once that is free.
// Reset: asynchronous, active low; idle, registers at 50 and 255, queue and output empty.
// ---------------------------------------------------------------------------
`include "dht22_pulse_width_receiver_macros.svh"

module dht22_pulse_width_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dpwr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  // Sample channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic                        line_level_i,
  // Reading channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic signed [dpwr_pkg::READING_W-1:0] humidity_tenths_o,
  output logic signed [dpwr_pkg::READING_W-1:0] temperature_tenths_o,
  output logic                        plausible_o,
  output logic [dpwr_pkg::TOTAL_W-1:0] bits_received_o
);
  import dpwr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  fifo_stat_t fifo_stat;
  frame_t     push_frame, head_frame;
  logic       push, pop;

  // Configuration registers: always ready, writes are registered.
  // Indexes beyond the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_THRESHOLD: cfg_d.bit_threshold = cfg_data_i;
        CFG_IDX_TIMEOUT:   cfg_d.timeout_count = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold <= BIT_THRESHOLD_RST;
      cfg_q.timeout_count <= TIMEOUT_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: count samples per phase, shift in data bits, close frames on
  // timeout or phase limit, and hand each closed frame to the queue.
  dpwr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg_q),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .frame_o      (push_frame)
  );

  // Queue: decouple the sampling side from a stalled reading consumer.
  dpwr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .pop_i   (pop),
    .stat_o  (fifo_stat),
    .head_o  (head_frame)
  );

  // Back: verify checksum, scale the readings and hold them in the output
  // register until the consumer takes the transfer.
  dpwr_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .fifo_stat_i          (fifo_stat),
    .head_i               (head_frame),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status_o),
    .humidity_tenths_o    (humidity_tenths_o),
    .temperature_tenths_o (temperature_tenths_o),
    .plausible_o          (plausible_o),
    .bits_received_o      (bits_received_o)
  );

  // Assertions
  `DPWR_ASSERT(a_no_push_when_full, clk_i, rst_ni, push |-> !fifo_stat.full, "frame pushed into full queue")
  `DPWR_ASSERT(a_pop_fills_output, clk_i, rst_ni, pop |=> out_valid_o, "popped frame did not reach output")
  `DPWR_ASSERT(a_ok_has_all_bits, clk_i, rst_ni, (out_valid_o && !status_o) |-> (bits_received_o == FRAME_BIT_COUNT), "accepted reading without full frame")
  `DPWR_ASSERT(a_fail_fallback, clk_i, rst_ni, (out_valid_o && status_o) |-> (humidity_tenths_o == READING_FAIL && !plausible_o), "failed reading not flagged")
  `DPWR_ASSERT_ALWAYS(a_reset_output_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

@@ rtl/core/dpwr_front.sv @@
// ---------------------------------------------------------------------------
// dpwr_front: sample classifier
// Counts equal line samples per phase, collects data bits and closes frames.
// ---------------------------------------------------------------------------
module dpwr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic                line_level_i,
  input  dpwr_pkg::cfg_t      cfg_i,
  input  dpwr_pkg::fifo_stat_t fifo_stat_i,
  output logic                push_o,
  output dpwr_pkg::frame_t    frame_o
);
  import dpwr_pkg::*;

  logic                  capturing_q, capturing_d;
  logic                  prev_level_q, prev_level_d;
  logic [7:0]            samples_q, samples_d;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [FRAME_BITS-1:0] bits_q, bits_d;
  logic                  accept;
  logic [7:0]            samples_inc;
  logic [PHASE_W-1:0]    phase_inc;

  assign in_ready_o  = !fifo_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign samples_inc = samples_q + 8'd1;
  assign phase_inc   = phase_q + 7'd1;

  always_comb begin
    capturing_d  = capturing_q;
    prev_level_d = prev_level_q;
    samples_d    = samples_q;
    phase_d      = phase_q;
    total_d      = total_q;
    bits_d       = bits_q;
    push_o       = 1'b0;
    if (accept) begin
      if (kind_i == KIND_START) begin
        capturing_d  = 1'b1;
        prev_level_d = 1'b1;
        samples_d    = '0;
        phase_d      = '0;
        total_d      = '0;
        bits_d       = '0;
      end else if (capturing_q) begin
        if (line_level_i == prev_level_q) begin
          samples_d = samples_inc;
          if (samples_inc == cfg_i.timeout_count) begin
            push_o      = 1'b1;
            capturing_d = 1'b0;
          end
        end else begin
          // Boundary sample: close the phase without counting it
          prev_level_d = line_level_i;
          if (phase_q >= FIRST_BIT_PHASE && !phase_q[0] && total_q < FRAME_BIT_COUNT) begin
            bits_d  = {bits_q[FRAME_BITS-2:0], samples_q > cfg_i.bit_threshold};
            total_d = total_q + 6'd1;
          end
          samples_d = '0;
          phase_d   = phase_inc;
          if (phase_inc >= PHASE_LIMIT_C) begin
            push_o      = 1'b1;
            capturing_d = 1'b0;
          end
        end
      end
    end
  end

  assign frame_o.bits  = bits_d;
  assign frame_o.total = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q  <= 1'b0;
      prev_level_q <= 1'b1;
      samples_q    <= '0;
      phase_q      <= '0;
      total_q      <= '0;
      bits_q       <= '0;
    end else begin
      capturing_q  <= capturing_d;
      prev_level_q <= prev_level_d;
      samples_q    <= samples_d;
      phase_q      <= phase_d;
      total_q      <= total_d;
      bits_q       <= bits_d;
    end
  end

endmodule

@@ rtl/core/dpwr_fifo.sv @@
// ---------------------------------------------------------------------------
// dpwr_fifo: frame queue
// Short queue of closed frames between the classifier and the decoder.
// ---------------------------------------------------------------------------
module dpwr_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dpwr_pkg::frame_t     frame_i,
  input  logic                 pop_i,
  output dpwr_pkg::fifo_stat_t stat_o,
  output dpwr_pkg::frame_t     head_o
);
  import dpwr_pkg::*;

  frame_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign stat_o.full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.not_empty = (count_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign head_o           = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/core/dpwr_back.sv @@
// ---------------------------------------------------------------------------
// dpwr_back: frame decoder
// Checks bit count and checksum, scales readings and holds the result.
// ---------------------------------------------------------------------------
module dpwr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpwr_pkg::fifo_stat_t        fifo_stat_i,
  input  dpwr_pkg::frame_t            head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic signed [dpwr_pkg::READING_W-1:0] humidity_tenths_o,
  output logic signed [dpwr_pkg::READING_W-1:0] temperature_tenths_o,
  output logic                        plausible_o,
  output logic [dpwr_pkg::TOTAL_W-1:0] bits_received_o
);
  import dpwr_pkg::*;

  function automatic logic [11:0] times_ten(input logic [7:0] v);
    logic [11:0] w;
    w = {4'b0, v};
    return (w << 3) + (w << 1);
  endfunction

  logic [7:0]                  d0, d1, d2, d3, d4;
  logic [9:0]                  byte_sum;
  logic                        ok;
  logic [15:0]                 hum_raw;
  logic [14:0]                 tmp_raw;
  logic [11:0]                 hum_mag, tmp_mag;
  logic signed [READING_W-1:0] hum_s, tmp_pos, tmp_s;
  logic                        plaus;

  logic                        out_valid_q;
  logic                        status_q, plausible_q;
  logic signed [READING_W-1:0] hum_q, tmp_q;
  logic [TOTAL_W-1:0]          total_q;

  assign d0 = head_i.bits[39:32];
  assign d1 = head_i.bits[31:24];
  assign d2 = head_i.bits[23:16];
  assign d3 = head_i.bits[15:8];
  assign d4 = head_i.bits[7:0];

  assign byte_sum = {2'b0, d0} + {2'b0, d1} + {2'b0, d2} + {2'b0, d3};
  assign ok       = (head_i.total >= FRAME_BIT_COUNT) && (d4 == byte_sum[7:0]);
  assign hum_raw  = {d0, d1};
  assign tmp_raw  = {d2[6:0], d3};

  // Over-range raw values fall back to the high byte times ten
  assign hum_mag = (hum_raw > 16'd1000) ? times_ten(d0) : hum_raw[11:0];
  assign tmp_mag = (tmp_raw > 15'd1250) ? times_ten(d2) : tmp_raw[11:0];
  assign tmp_pos = $signed({1'b0, tmp_mag});

  assign hum_s = ok ? $signed({1'b0, hum_mag}) : READING_FAIL;
  assign tmp_s = ok ? (d2[7] ? -tmp_pos : tmp_pos) : READING_FAIL;
  assign plaus = (hum_s > 13'sd0) && (tmp_s > -13'sd400) && (tmp_s < 13'sd1250);

  assign pop_o = fifo_stat_i.not_empty && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q    <= !ok;
      hum_q       <= hum_s;
      tmp_q       <= tmp_s;
      plausible_q <= plaus;
      total_q     <= head_i.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign humidity_tenths_o    = hum_q;
  assign temperature_tenths_o = tmp_q;
  assign plausible_o          = plausible_q;
  assign bits_received_o      = total_q;

endmodule
